FILE: src/wtr_pkg.sv
// ----------------------------------------------------------------------------
// wtr_pkg
// shared types, sizes and codes of the wavelet tree rank engine
// ----------------------------------------------------------------------------
package wtr_pkg;

  // text store sizing (MAX_TEXT a power of two)
  localparam int MAX_TEXT    = 4096;
  localparam int MAX_SYMBOLS = 8;
  localparam int LANES       = (MAX_TEXT >= 128) ? 64 : MAX_TEXT / 2;
  localparam int WORDS       = MAX_TEXT / LANES;
  localparam int LANE_W      = $clog2(LANES);
  localparam int ADDR_W      = $clog2(WORDS);
  localparam int LEN_W       = $clog2(MAX_TEXT + 1);
  localparam int SYM_W       = 3;
  localparam int WORD_W      = LANES * SYM_W;
  localparam int PC_W        = LANE_W + 1;

  // fixed field widths
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 12;
  localparam int RANK_W  = 13;
  localparam int STAT_W  = 2;
  localparam int CMP_W   = (LEN_W > POS_W) ? LEN_W : POS_W;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;
  localparam int SIZE_W     = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_CHARS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SIZE  = 1'd1;
  localparam logic [SIZE_W-1:0]    ALPHA_SIZE_RST  = 4'd4;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOSYM = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] symbol;
    logic [POS_W-1:0]  position;
  } req_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank_count;
    logic [STAT_W-1:0] status;
  } resp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APP_RD,
    ST_APP_WR,
    ST_Q_RUN,
    ST_Q_DRAIN,
    ST_RESP
  } state_t;

endpackage

FILE: src/wtr_ram.sv
// ----------------------------------------------------------------------------
// wtr_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module wtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/wavelet_tree_rank_engine.sv
// ----------------------------------------------------------------------------
// wavelet_tree_rank_engine
// symbol text store with rank queries over a configurable alphabet
// ----------------------------------------------------------------------------
// The text is held as one 3-bit alphabet index per position, packed 64
// positions to a word in a single synchronous ram (64 words of 192 bits).
// Every request gives exactly one response. An append reads the tail
// word, writes it back with the new lane, then gives its response.
// A rank query reads the words from position 0 up to the word holding the
// queried position, one word a cycle, and counts matching lanes through a
// compare and popcount stage and an accumulator. Clear, rejected and
// unknown requests go straight to the response. A response waits in an
// output register while the next request is taken. Configuration may be
// written only while the block is idle. Stale lanes past the text end are
// never counted, so the ram needs no clearing after reset or clear.
// ----------------------------------------------------------------------------
module wavelet_tree_rank_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  wtr_pkg::req_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output wtr_pkg::resp_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [wtr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wtr_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // configuration registers
  logic [wtr_pkg::CFG_DATA_W-1:0] alpha_chars;
  logic [wtr_pkg::SIZE_W-1:0]     alpha_size;

  // control
  wtr_pkg::state_t state, state_next;
  logic [wtr_pkg::LEN_W-1:0] text_len;

  // request held during work
  logic [wtr_pkg::SYM_W-1:0]  q_idx;
  logic [wtr_pkg::POS_W-1:0]  q_pos;
  logic [wtr_pkg::ADDR_W-1:0] q_word;
  logic [wtr_pkg::ADDR_W-1:0] q_last_word;
  logic [wtr_pkg::STAT_W-1:0] r_status;

  // count pipeline
  logic                       rd_v, rd_last;
  logic                       pc_v, pc_last;
  logic [wtr_pkg::PC_W-1:0]   pc;
  logic [wtr_pkg::LEN_W-1:0]  acc;

  // ram port
  logic                        ram_we;
  logic [wtr_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [wtr_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;

  // request decode
  logic                       in_accept;
  logic [wtr_pkg::SIZE_W-1:0] used_size;
  logic                       sym_found;
  logic [wtr_pkg::SYM_W-1:0]  sym_idx;
  logic                       app_full;
  logic                       q_range;
  logic [wtr_pkg::LEN_W-1:0]  len_shift;
  logic [wtr_pkg::LEN_W-1:0]  pos_shift;
  logic [wtr_pkg::LANE_W-1:0] tail_lane;
  logic [wtr_pkg::PC_W-1:0]   pc_calc;
  logic                       out_free;
  logic [wtr_pkg::STAT_W-1:0] req_status;
  logic [wtr_pkg::SYM_W-1:0]  req_idx;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign tail_lane = text_len[wtr_pkg::LANE_W-1:0];
  assign len_shift = text_len >> wtr_pkg::LANE_W;
  assign pos_shift = wtr_pkg::LEN_W'(in_data.position) >> wtr_pkg::LANE_W;

  // clamp the alphabet size to 2..MAX_SYMBOLS
  always_comb begin
    if (alpha_size < wtr_pkg::SIZE_W'(2)) begin
      used_size = wtr_pkg::SIZE_W'(2);
    end else if (alpha_size > wtr_pkg::SIZE_W'(wtr_pkg::MAX_SYMBOLS)) begin
      used_size = wtr_pkg::SIZE_W'(wtr_pkg::MAX_SYMBOLS);
    end else begin
      used_size = alpha_size;
    end
  end

  // alphabet lookup, lowest matching index wins
  always_comb begin
    sym_found = 1'b0;
    sym_idx   = '0;
    for (int k = 0; k < wtr_pkg::MAX_SYMBOLS; k++) begin
      if (!sym_found && (wtr_pkg::SIZE_W'(k) < used_size) &&
          (alpha_chars[8*k +: 8] == in_data.symbol)) begin
        sym_found = 1'b1;
        sym_idx   = wtr_pkg::SYM_W'(k);
      end
    end
  end

  assign app_full = (text_len >= wtr_pkg::LEN_W'(wtr_pkg::MAX_TEXT));
  assign q_range  = (wtr_pkg::CMP_W'(in_data.position) >= wtr_pkg::CMP_W'(text_len));

  // status and stored index of the incoming request
  always_comb begin
    req_status = wtr_pkg::STAT_OK;
    req_idx    = sym_idx;
    case (in_data.operation)
      wtr_pkg::OP_APPEND: begin
        if (app_full) begin
          req_status = wtr_pkg::STAT_FULL;
        end
        // a byte outside the alphabet goes to the last symbol
        if (!sym_found) begin
          req_idx = wtr_pkg::SYM_W'(used_size - wtr_pkg::SIZE_W'(1));
        end
      end
      wtr_pkg::OP_QUERY: begin
        if (q_range) begin
          req_status = wtr_pkg::STAT_RANGE;
        end else if (!sym_found) begin
          req_status = wtr_pkg::STAT_NOSYM;
        end
      end
      default: ;
    endcase
  end

  // match and popcount over the word just read, lanes past the position masked
  always_comb begin
    pc_calc = '0;
    for (int l = 0; l < wtr_pkg::LANES; l++) begin
      if ((ram_rdata[l*wtr_pkg::SYM_W +: wtr_pkg::SYM_W] == q_idx) &&
          (!rd_last || (wtr_pkg::LANE_W'(l) <= q_pos[wtr_pkg::LANE_W-1:0]))) begin
        pc_calc = pc_calc + wtr_pkg::PC_W'(1);
      end
    end
  end

  // tail word with the appended lane replaced
  always_comb begin
    ram_wdata = ram_rdata;
    ram_wdata[tail_lane*wtr_pkg::SYM_W +: wtr_pkg::SYM_W] = q_idx;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wtr_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_data.operation)
            wtr_pkg::OP_APPEND:
              state_next = app_full ? wtr_pkg::ST_RESP : wtr_pkg::ST_APP_RD;
            wtr_pkg::OP_QUERY:
              state_next = (q_range || !sym_found) ? wtr_pkg::ST_RESP : wtr_pkg::ST_Q_RUN;
            default:
              state_next = wtr_pkg::ST_RESP;
          endcase
        end
      end
      wtr_pkg::ST_APP_RD:  state_next = wtr_pkg::ST_APP_WR;
      wtr_pkg::ST_APP_WR:  state_next = wtr_pkg::ST_RESP;
      wtr_pkg::ST_Q_RUN: begin
        if (q_word == q_last_word) begin
          state_next = wtr_pkg::ST_Q_DRAIN;
        end
      end
      wtr_pkg::ST_Q_DRAIN: begin
        if (pc_v && pc_last) begin
          state_next = wtr_pkg::ST_RESP;
        end
      end
      wtr_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = wtr_pkg::ST_IDLE;
        end
      end
      default: state_next = wtr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: ram port and input stall
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = len_shift[wtr_pkg::ADDR_W-1:0];
    ram_raddr = len_shift[wtr_pkg::ADDR_W-1:0];
    case (state)
      wtr_pkg::ST_IDLE:   in_stall  = 1'b0;
      wtr_pkg::ST_APP_WR: ram_we    = 1'b1;
      wtr_pkg::ST_Q_RUN:  ram_raddr = q_word;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= wtr_pkg::ST_IDLE;
      text_len    <= '0;
      alpha_chars <= '0;
      alpha_size  <= wtr_pkg::ALPHA_SIZE_RST;
      out_valid   <= 1'b0;
      rd_v        <= 1'b0;
      pc_v        <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= (state == wtr_pkg::ST_Q_RUN);
      pc_v  <= rd_v;
      if (cfg_we) begin
        case (cfg_index)
          wtr_pkg::CFG_ALPHA_CHARS: alpha_chars <= cfg_data;
          wtr_pkg::CFG_ALPHA_SIZE:  alpha_size  <= cfg_data[wtr_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_accept && (in_data.operation == wtr_pkg::OP_CLEAR)) begin
        text_len <= '0;
      end else if (state == wtr_pkg::ST_APP_WR) begin
        text_len <= text_len + wtr_pkg::LEN_W'(1);
      end
      if ((state == wtr_pkg::ST_RESP) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      r_status    <= req_status;
      q_pos       <= in_data.position;
      q_last_word <= pos_shift[wtr_pkg::ADDR_W-1:0];
      q_idx       <= req_idx;
    end
    if (in_accept) begin
      q_word <= '0;
    end else if (state == wtr_pkg::ST_Q_RUN) begin
      q_word <= q_word + wtr_pkg::ADDR_W'(1);
    end
    rd_last     <= (q_word == q_last_word);
    pc          <= pc_calc;
    pc_last     <= rd_v && rd_last;
    if (in_accept) begin
      acc <= '0;
    end else if (pc_v) begin
      acc <= acc + wtr_pkg::LEN_W'(pc);
    end
    if ((state == wtr_pkg::ST_RESP) && out_free) begin
      out_data.rank_count <= wtr_pkg::RANK_W'(acc);
      out_data.status     <= r_status;
    end
  end

  wtr_ram #(
    .WIDTH (wtr_pkg::WORD_W),
    .DEPTH (wtr_pkg::WORDS)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef ASSERT_OFF
  // rejected responses carry no count
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != wtr_pkg::STAT_OK) |-> out_data.rank_count == '0)
    else $error("nonzero count on failed request");

  // text length never passes the store size
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    text_len <= wtr_pkg::LEN_W'(wtr_pkg::MAX_TEXT))
    else $error("text length past store size");

  // an append write grows the text by exactly one
  a_app_grow: assert property (@(posedge clk) disable iff (rst)
    (state == wtr_pkg::ST_APP_WR) |=> text_len == $past(text_len) + wtr_pkg::LEN_W'(1))
    else $error("append did not grow text");

  // the final popcount of a query ends the drain
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (state == wtr_pkg::ST_Q_DRAIN && pc_v && pc_last) |=> state == wtr_pkg::ST_RESP)
    else $error("query drain did not finish");
`endif

endmodule
